/* sv/csrf_pkg.sv */
package csrf_pkg;

	// Command codes carried on the input tuser field
	typedef enum logic [2:0] {
		OP_ROW   = 3'd0,
		OP_COL   = 3'd1,
		OP_RECT  = 3'd2,
		OP_READ  = 3'd3,
		OP_SCALE = 3'd4
	} opcode_t;

	// Configuration register indexes
	localparam logic [1:0] CFG_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_HEIGHT = 2'd1;
	localparam logic [1:0] CFG_COLOR  = 2'd2;

	localparam int unsigned OP_W    = 3;
	localparam int unsigned COORD_W = 16;
	localparam int unsigned PIXEL_W = 32;
	localparam int unsigned SIZE_W  = 9;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned IN_DATA_W = 96;

	// Controller to datapath
	typedef struct packed {
		logic take;       // latch the accepted command beat
		logic setup;      // load scanner bounds from the latched command
		logic clr_load;   // load scanner with the full store for the clearing pass
		logic step;       // advance the scanner one pixel
		logic write;      // write the pixel under the scanner
		logic wsel_clear; // write zero instead of the draw color
		logic scan_read;  // read the pixel under the scanner into the scale pipe
		logic read;       // read the pixel under the scanner for a read command
		logic post;       // load the result register
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [2:0] op;        // latched opcode
		logic       draw_ok;   // latched draw command covers at least one pixel
		logic       scan_last; // scanner sits on its last pixel
		logic       pipe_busy; // scale pipe still holds pixels
		logic       out_free;  // result register can take a new beat
	} dp_status_t;

endpackage

/* sv/clipped_span_rect_fill_engine.sv */
// Drawing engine over a frame store of one RGBA word per pixel.
// Commands come in on the s_axis channel: tuser carries the opcode
// (row span, column span, rectangle, read pixel, multiply surface) and
// tdata the coordinates and the multiplier. Each command gives one result
// beat on m_axis: tdata is the pixel for a read and zero otherwise, tuser
// echoes the opcode.
// Surface size and draw color are written on the cfg channel (index 0 width,
// 1 height, 2 color) while no command is in flight; cfg_ready is always high.
// A span or rectangle paints one pixel a cycle through the single store
// write port; a multiply does one read-modify-write per cycle through a
// two-stage scale pipe over the width times height surface in use.
// Commands run one at a time. The result sits in an output register, so the
// next command is taken while a result waits; the engine stalls only when
// it has a second result ready and the receiver still holds off.
// After reset the store is cleared one word a cycle, MAX_WIDTH*MAX_HEIGHT
// words (65536 at the defaults), and s_axis_tready stays low until then.
module clipped_span_rect_fill_engine #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// x_first[15:0], y_first[31:16], x_second[47:32], y_second[63:48],
	// scale_color[95:64]
	input  logic [95:0] s_axis_tdata,
	// opcode[2:0]
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// pixel_value[31:0]
	output logic [31:0] m_axis_tdata,
	// finished_kind[2:0]
	output logic [2:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import csrf_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	csrf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	csrf_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

/* sv/csrf_ctrl.sv */
module csrf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  csrf_pkg::dp_status_t  status,
	output csrf_pkg::ctrl_cmd_t   cmd
);
	import csrf_pkg::*;

	typedef enum logic [3:0] {
		ST_CLR_LOAD,
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_PAINT,
		ST_READ,
		ST_SCALE,
		ST_DRAIN,
		ST_DONE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	// Command decode from state
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLR_LOAD: cmd.clr_load = 1'b1;
			ST_CLEAR: begin
				cmd.write      = 1'b1;
				cmd.wsel_clear = 1'b1;
				cmd.step       = 1'b1;
			end
			ST_IDLE:  cmd.take = in_valid;
			ST_SETUP: cmd.setup = 1'b1;
			ST_PAINT: begin
				cmd.write = 1'b1;
				cmd.step  = 1'b1;
			end
			ST_READ:  cmd.read = 1'b1;
			ST_SCALE: begin
				cmd.scan_read = 1'b1;
				cmd.step      = 1'b1;
			end
			ST_DRAIN: cmd = '0;
			ST_DONE:  cmd.post = status.out_free;
			default:  cmd = '0;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR_LOAD;
		end else begin
			unique case (state_q)
				ST_CLR_LOAD: state_q <= ST_CLEAR;
				ST_CLEAR: if (status.scan_last) state_q <= ST_IDLE;
				ST_IDLE:  if (in_valid) state_q <= ST_SETUP;
				ST_SETUP: begin
					case (status.op) inside
						OP_ROW, OP_COL, OP_RECT:
							state_q <= status.draw_ok ? ST_PAINT : ST_DONE;
						OP_READ:  state_q <= ST_READ;
						OP_SCALE: state_q <= ST_SCALE;
						default:  state_q <= ST_DONE;
					endcase
				end
				ST_PAINT: if (status.scan_last) state_q <= ST_DONE;
				ST_READ:  state_q <= ST_DONE;
				ST_SCALE: if (status.scan_last) state_q <= ST_DRAIN;
				ST_DRAIN: if (!status.pipe_busy) state_q <= ST_DONE;
				ST_DONE:  if (status.out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// A result is only posted once the previous one has left
	a_post_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |-> status.out_free)
		else $error("result posted over a waiting beat");

	// No command is taken until the clearing pass is over
	a_no_take_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !in_ready)
		else $error("input ready during clearing pass");

	// Scale pipe must be empty when the result is posted
	a_drained: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.post |-> !status.pipe_busy)
		else $error("result posted with scale pipe busy");

endmodule

/* sv/csrf_dpath.sv */
module csrf_dpath #(
	parameter int unsigned MAX_WIDTH  = 256,
	parameter int unsigned MAX_HEIGHT = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [csrf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [csrf_pkg::PIXEL_W-1:0]     cfg_data,
	input  logic [csrf_pkg::IN_DATA_W-1:0]   in_data,
	input  logic [csrf_pkg::OP_W-1:0]        in_user,
	output logic [csrf_pkg::PIXEL_W-1:0]     out_data,
	output logic [csrf_pkg::OP_W-1:0]        out_user,
	output logic                             out_valid,
	input  logic                             out_ready,
	input  csrf_pkg::ctrl_cmd_t              cmd,
	output csrf_pkg::dp_status_t             status
);
	import csrf_pkg::*;

	localparam int unsigned XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int unsigned YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Clamp a signed coordinate to 0..hi
	function automatic logic [12:0] clamp13(input logic signed [16:0] v,
		input logic [12:0] hi);
		logic signed [16:0] hs;
		hs = $signed({4'b0000, hi});
		if (v < 0) return 13'd0;
		else if (v > hs) return hi;
		else return v[12:0];
	endfunction

	// Configuration registers
	logic [SIZE_W-1:0]  width_q, height_q;
	logic [PIXEL_W-1:0] color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_W'(256);
			height_q <= SIZE_W'(256);
			color_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data[SIZE_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[SIZE_W-1:0];
				CFG_COLOR:  color_q  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// Last valid column and row of the surface in use
	logic [12:0] wm, hm;
	always_comb begin
		if (width_q == '0) wm = 13'd0;
		else if (13'(width_q) > 13'(MAX_WIDTH)) wm = 13'(MAX_WIDTH - 1);
		else wm = 13'(width_q) - 13'd1;
		if (height_q == '0) hm = 13'd0;
		else if (13'(height_q) > 13'(MAX_HEIGHT)) hm = 13'(MAX_HEIGHT - 1);
		else hm = 13'(height_q) - 13'd1;
	end

	// Command latch, with per-axis ordering done on the way in
	logic [2:0]                 op_q;
	logic signed [COORD_W-1:0]  x1_q, y1_q, xlo_q, xhi_q, ylo_q, yhi_q;
	logic [PIXEL_W-1:0]         scale_q;
	logic signed [COORD_W-1:0]  ix1, iy1, ix2, iy2;

	assign ix1 = in_data[15:0];
	assign iy1 = in_data[31:16];
	assign ix2 = in_data[47:32];
	assign iy2 = in_data[63:48];

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q    <= in_user;
			x1_q    <= ix1;
			y1_q    <= iy1;
			xlo_q   <= (ix1 > ix2) ? ix2 : ix1;
			xhi_q   <= (ix1 > ix2) ? ix1 : ix2;
			ylo_q   <= (iy1 > iy2) ? iy2 : iy1;
			yhi_q   <= (iy1 > iy2) ? iy1 : iy2;
			scale_q <= in_data[95:64];
		end
	end

	// Unclamped inclusive bounds of the latched command
	logic signed [16:0] bx0, bx1, by0, by1, dx, dy;
	logic               wider, draw_ok;
	always_comb begin
		dx    = 17'(xhi_q) - 17'(xlo_q);
		dy    = 17'(yhi_q) - 17'(ylo_q);
		wider = dx > dy;
		bx0 = 17'(x1_q);
		bx1 = 17'(x1_q);
		by0 = 17'(y1_q);
		by1 = 17'(y1_q);
		draw_ok = 1'b0;
		case (op_q)
			OP_ROW: begin
				bx0 = 17'(xlo_q);
				bx1 = 17'(xhi_q);
				draw_ok = 1'b1;
			end
			OP_COL: begin
				by0 = 17'(ylo_q);
				by1 = 17'(yhi_q);
				draw_ok = 1'b1;
			end
			OP_RECT: begin
				bx0 = 17'(xlo_q);
				by0 = 17'(ylo_q);
				if (wider) begin
					bx1 = 17'(xhi_q);
					by1 = 17'(yhi_q) - 17'sd1;
					draw_ok = ylo_q < yhi_q;
				end else begin
					bx1 = 17'(xhi_q) - 17'sd1;
					by1 = 17'(yhi_q);
					draw_ok = xlo_q < xhi_q;
				end
			end
			default: ;
		endcase
	end

	// Raster scanner
	logic [XW-1:0] x_q, xa_q, xb_q;
	logic [YW-1:0] y_q, yb_q;
	logic          scan_last;
	logic [AW-1:0] addr;

	assign scan_last = (x_q == xb_q) && (y_q == yb_q);
	assign addr      = AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q);

	always_ff @(posedge clk) begin
		if (cmd.clr_load) begin
			xa_q <= '0;
			x_q  <= '0;
			xb_q <= XW'(MAX_WIDTH - 1);
			y_q  <= '0;
			yb_q <= YW'(MAX_HEIGHT - 1);
		end else if (cmd.setup) begin
			if (op_q == OP_SCALE) begin
				xa_q <= '0;
				x_q  <= '0;
				xb_q <= wm[XW-1:0];
				y_q  <= '0;
				yb_q <= hm[YW-1:0];
			end else begin
				xa_q <= XW'(clamp13(bx0, wm));
				x_q  <= XW'(clamp13(bx0, wm));
				xb_q <= XW'(clamp13(bx1, wm));
				y_q  <= YW'(clamp13(by0, hm));
				yb_q <= YW'(clamp13(by1, hm));
			end
		end else if (cmd.step) begin
			if (x_q == xb_q) begin
				x_q <= xa_q;
				y_q <= y_q + YW'(1);
			end else begin
				x_q <= x_q + XW'(1);
			end
		end
	end

	// Frame store: one write port, one registered read port
	logic [PIXEL_W-1:0] mem_q [DEPTH];
	logic [PIXEL_W-1:0] rd_data_q;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [PIXEL_W-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (cmd.read || cmd.scan_read) rd_data_q <= mem_q[addr];
	end

	// Scale pipe: s1 has the read word, s2 the channel products
	logic               valid_s1, valid_s2;
	logic [AW-1:0]      addr_s1, addr_s2;
	logic [15:0]        prod_s2 [4];
	logic [PIXEL_W-1:0] scaled;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_read;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= addr;
		addr_s2 <= addr_s1;
		for (int c = 0; c < 4; c++) begin
			prod_s2[c] <= 16'(rd_data_q[8*c +: 8]) * 16'(scale_q[8*c +: 8]);
		end
	end

	// floor(p/255) for p up to 255*255: (p + (p >> 8) + 1) >> 8
	always_comb begin
		logic [16:0] sum;
		for (int c = 0; c < 4; c++) begin
			sum = 17'(prod_s2[c]) + 17'(prod_s2[c][15:8]) + 17'd1;
			scaled[8*c +: 8] = sum[15:8];
		end
	end

	// Write port select
	always_comb begin
		we    = cmd.write || valid_s2;
		waddr = valid_s2 ? addr_s2 : addr;
		if (valid_s2) wdata = scaled;
		else if (cmd.wsel_clear) wdata = '0;
		else wdata = color_q;
	end

	// Result register
	logic               out_valid_q;
	logic [PIXEL_W-1:0] out_data_q;
	logic [2:0]         out_user_q;
	logic               out_free;

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			out_data_q <= (op_q == OP_READ) ? rd_data_q : '0;
			out_user_q <= op_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	assign status.op        = op_q;
	assign status.draw_ok   = draw_ok;
	assign status.scan_last = scan_last;
	assign status.pipe_busy = valid_s1 || valid_s2;
	assign status.out_free  = out_free;

	// Direct writes never meet a scaled write on the single port
	a_port_conflict: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !cmd.write)
		else $error("direct write collides with scaled write");

	// Scanner stays inside its bounds while painting
	a_scan_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.write && !cmd.wsel_clear) |-> (x_q <= xb_q && y_q <= yb_q))
		else $error("scanner outside its bounds");

	// Scale reads stay on the surface in use
	a_scale_surface: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_read |-> (13'(x_q) <= wm && 13'(y_q) <= hm))
		else $error("scale read outside the surface");

	// Every scale read comes out of the pipe at s2 to be written back
	a_scale_latency: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_read |-> ##2 valid_s2)
		else $error("scale pipe lost a pixel");

endmodule

/* dv/tb_clipped_span_rect_fill_engine.sv */
`timescale 1ns / 100ps

module tb_clipped_span_rect_fill_engine;
	import csrf_pkg::*;

	localparam int MAX_W          = 256;
	localparam int MAX_H          = 256;
	localparam int CHAN_MAX       = 255;
	localparam int RESET_CYCLES   = 12;
	localparam int RAND_PHASES    = 12;
	localparam int CMDS_PER_PHASE = 154;
	localparam int CALM_PHASES    = 2;
	localparam int HOLD_AT        = 60;
	localparam int HOLD_CYCLES    = 400;
	localparam int TAIL_CYCLES    = 16;
	// clearing pass, one full-size multiply, then every random command at its
	// largest area with the longest gap and stall, taken about four times over
	localparam int CYCLE_LIMIT    = 9000000;

	typedef struct {
		logic [2:0]         op;
		logic signed [15:0] x1;
		logic signed [15:0] y1;
		logic signed [15:0] x2;
		logic signed [15:0] y2;
		logic [31:0]        scale;
	} draw_cmd_t;

	typedef struct {
		logic [31:0] pixel;
		logic [2:0]  kind;
	} finish_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	// x_first[15:0], y_first[31:16], x_second[47:32], y_second[63:48],
	// scale_color[95:64]
	logic [95:0] s_axis_tdata = '0;
	// opcode[2:0]
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	// pixel_value[31:0]
	logic [31:0] m_axis_tdata;
	// finished_kind[2:0]
	logic [2:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	// shadow of the frame and the surface registers
	bit [31:0] frame_shadow [MAX_W*MAX_H];
	bit [8:0]  shadow_w = 9'd256;
	bit [8:0]  shadow_h = 9'd256;
	bit [31:0] shadow_color = '0;

	draw_cmd_t    draw_cmds [$];
	finish_beat_t pending_finishes [$];
	draw_cmd_t    cur_cmd;

	bit src_idle_on = 1'b0;
	bit sink_idle_on = 1'b0;
	int src_gap = 0;
	int sink_stall = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int cmds_sent = 0;
	int beats_checked = 0;
	int fail_count = 0;
	int cycle_count = 0;

	clipped_span_rect_fill_engine #(
		.MAX_WIDTH (MAX_W),
		.MAX_HEIGHT(MAX_H)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #6 clk = ~clk;

	// effective surface size: zero counts as one, oversize as the maximum
	function automatic int surf_cols();
		if (shadow_w == 0) return 1;
		if (shadow_w > MAX_W) return MAX_W;
		return int'(shadow_w);
	endfunction

	function automatic int surf_rows();
		if (shadow_h == 0) return 1;
		if (shadow_h > MAX_H) return MAX_H;
		return int'(shadow_h);
	endfunction

	function automatic int clamp_edge(input int v, input int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	// fill the inclusive block after clamping every bound to the surface
	function automatic void paint_block(input int xa, input int xb, input int ya, input int yb);
		int x;
		int y;
		xa = clamp_edge(xa, surf_cols() - 1);
		xb = clamp_edge(xb, surf_cols() - 1);
		ya = clamp_edge(ya, surf_rows() - 1);
		yb = clamp_edge(yb, surf_rows() - 1);
		for (y = ya; y <= yb; y++)
			for (x = xa; x <= xb; x++)
				frame_shadow[y*MAX_W + x] = shadow_color;
	endfunction

	function automatic logic [31:0] scale_pixel(input logic [31:0] p, input logic [31:0] m);
		logic [31:0] r;
		int unsigned c;
		int unsigned k;
		int          s;
		for (s = 0; s < 4; s++) begin
			c = p[8*s +: 8];
			k = m[8*s +: 8];
			r[8*s +: 8] = 8'((c * k) / CHAN_MAX);
		end
		return r;
	endfunction

	// apply one command to the shadow frame, return the expected pixel_value
	function automatic logic [31:0] run_draw_cmd(input draw_cmd_t c);
		int x1;
		int y1;
		int x2;
		int y2;
		int t;
		int x;
		int y;
		logic [31:0] pix;
		x1 = c.x1;
		y1 = c.y1;
		x2 = c.x2;
		y2 = c.y2;
		pix = '0;
		case (c.op)
			OP_ROW: begin
				if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
				paint_block(x1, x2, y1, y1);
			end
			OP_COL: begin
				if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
				paint_block(x1, x1, y1, y2);
			end
			OP_RECT: begin
				if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
				if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
				// wider than tall: rows, else columns; the last row/column is left out
				if (x2 - x1 > y2 - y1) begin
					if (y1 < y2) paint_block(x1, x2, y1, y2 - 1);
				end else if (x1 < x2) begin
					paint_block(x1, x2 - 1, y1, y2);
				end
			end
			OP_READ: begin
				pix = frame_shadow[clamp_edge(y1, surf_rows() - 1)*MAX_W
					+ clamp_edge(x1, surf_cols() - 1)];
			end
			OP_SCALE: begin
				for (y = 0; y < surf_rows(); y++)
					for (x = 0; x < surf_cols(); x++)
						frame_shadow[y*MAX_W + x] = scale_pixel(frame_shadow[y*MAX_W + x], c.scale);
			end
			default: ;
		endcase
		return pix;
	endfunction

	// coordinate mostly near the surface, sometimes far out or at an extreme
	function automatic logic [15:0] rand_coord(input int extent);
		case ($urandom_range(0, 9))
			0: return 16'($urandom);
			1: begin
				case ($urandom_range(0, 5))
					0: return 16'h8000;
					1: return 16'h7FFF;
					2: return 16'hFFFF;
					3: return 16'h0000;
					4: return 16'(extent - 1);
					default: return 16'(extent);
				endcase
			end
			default: return 16'($urandom_range(0, extent + 7) - 4);
		endcase
	endfunction

	function automatic logic [8:0] big_size();
		return ($urandom_range(0, 1) != 0) ? 9'd256 : 9'($urandom_range(257, 511));
	endfunction

	task automatic queue_cmd(input logic [2:0] op, input int x1, input int y1,
			input int x2, input int y2, input logic [31:0] scale);
		draw_cmd_t c;
		c.op = op;
		c.x1 = 16'(x1);
		c.y1 = 16'(y1);
		c.x2 = 16'(x2);
		c.y2 = 16'(y2);
		c.scale = scale;
		draw_cmds.push_back(c);
	endtask

	// write all three surface registers back to back, block idle
	task automatic start_phase(input logic [8:0] w, input logic [8:0] h,
			input logic [31:0] color, input bit src_idle, input bit sink_idle);
		logic [1:0]  idx [3];
		logic [31:0] vals [3];
		int i;
		idx[0] = CFG_WIDTH;
		idx[1] = CFG_HEIGHT;
		idx[2] = CFG_COLOR;
		vals[0] = 32'(w);
		vals[1] = 32'(h);
		vals[2] = color;
		@(posedge clk);
		src_idle_on <= src_idle;
		sink_idle_on <= sink_idle;
		for (i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			case (idx[i])
				CFG_WIDTH:  shadow_w = vals[i][8:0];
				CFG_HEIGHT: shadow_h = vals[i][8:0];
				default:    shadow_color = vals[i];
			endcase
		end
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (draw_cmds.size() != 0 || s_axis_tvalid || pending_finishes.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// command driver: predicts on each accepted beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				pending_finishes.push_back('{pixel: run_draw_cmd(cur_cmd), kind: cur_cmd.op});
				cmds_sent++;
				if (src_idle_on && $urandom_range(0, 3) == 0)
					src_gap = $urandom_range(1, 3);
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (draw_cmds.size() > 0) begin
					cur_cmd = draw_cmds.pop_front();
					s_axis_tdata <= {cur_cmd.scale, cur_cmd.y2, cur_cmd.x2, cur_cmd.y1, cur_cmd.x1};
					s_axis_tuser <= cur_cmd.op;
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver backpressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_finishes.size() == 0) begin
					$error("result beat with no command outstanding: pixel_value %h finished_kind %0d",
						m_axis_tdata, m_axis_tuser);
					fail_count++;
				end else begin
					finish_beat_t e;
					e = pending_finishes.pop_front();
					if (m_axis_tdata !== e.pixel) begin
						$error("pixel_value mismatch: expected %h, got %h", e.pixel, m_axis_tdata);
						fail_count++;
					end
					if (m_axis_tuser !== e.kind) begin
						$error("finished_kind mismatch: expected %0d, got %0d", e.kind, m_axis_tuser);
						fail_count++;
					end
				end
				beats_checked++;
			end
			// one long hold-off so the engine fills and stalls its input
			if (!hold_done && beats_checked >= HOLD_AT) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_stall > 0) begin
				sink_stall--;
				m_axis_tready <= 1'b0;
			end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
				sink_stall = $urandom_range(0, 2);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		draw_cmd_t   c;
		logic [8:0]  w;
		logic [8:0]  h;
		logic [31:0] color;
		bit          src_idle;
		bit          sink_idle;
		int          p;
		int          n;
		int          b;
		int          k;
		int          r;
		int          directed;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// small surface: clamping, ordering, rectangle branches, unused opcodes
		start_phase(9'd16, 9'd12, 32'hA1B2C3D4, 1'b1, 1'b1);
		queue_cmd(OP_ROW, -32768, -32768, 32767, 0, '0);
		queue_cmd(OP_COL, 32767, 32767, 0, -32768, '0);
		queue_cmd(OP_ROW, 9, 4, 2, 0, '0);
		queue_cmd(OP_ROW, 7, 7, 7, 0, '0);
		queue_cmd(OP_RECT, 10, 8, 1, 6, '0);
		queue_cmd(OP_RECT, 12, 1, 13, 9, '0);
		queue_cmd(OP_RECT, 3, 3, 5, 5, '0);
		queue_cmd(OP_RECT, 0, 9, 8, 9, '0);
		queue_cmd(OP_RECT, 5, 0, 5, 11, '0);
		queue_cmd(OP_RECT, -100, -50, -20, -10, '0);
		queue_cmd(OP_READ, 32767, 32767, 0, 0, '0);
		queue_cmd(OP_READ, 5, 4, 0, 0, '0);
		queue_cmd(OP_SCALE, 0, 0, 0, 0, 32'h80FF00C0);
		queue_cmd(OP_READ, -32768, -32768, 0, 0, '0);
		for (k = 1; k <= 3; k++)
			queue_cmd(3'(OP_SCALE + k), k, -k, 32767, -32768, '1);
		wait_drained();

		// zero size counts as one pixel
		start_phase(9'd0, 9'd0, 32'h12345678, 1'b0, 1'b1);
		queue_cmd(OP_ROW, -5, 3, 40, 0, '0);
		queue_cmd(OP_SCALE, 0, 0, 0, 0, 32'hFEFDFCFB);
		queue_cmd(OP_READ, 100, 100, 0, 0, '0);
		wait_drained();

		// oversize counts as the maximum surface
		start_phase(9'd511, 9'd300, 32'hFFFFFFFF, 1'b1, 1'b0);
		queue_cmd(OP_ROW, -32768, 255, 32767, 0, '0);
		queue_cmd(OP_COL, 255, -32768, 0, 32767, '0);
		queue_cmd(OP_SCALE, 0, 0, 0, 0, 32'hFF80FF01);
		queue_cmd(OP_READ, 32767, 32767, 0, 0, '0);
		wait_drained();
		directed = cmds_sent;

		// random phases: half small surfaces, half wide or tall strips
		for (p = 0; p < RAND_PHASES; p++) begin
			case (p % 4)
				1: begin w = big_size(); h = 9'($urandom_range(0, 4)); end
				2: begin w = 9'($urandom_range(0, 4)); h = big_size(); end
				default: begin w = 9'($urandom_range(1, 24)); h = 9'($urandom_range(1, 24)); end
			endcase
			src_idle = ($urandom_range(0, 3) != 0);
			sink_idle = ($urandom_range(0, 3) != 0);
			if (p == 0) begin
				// short commands back to back while the receiver holds off
				w = 9'($urandom_range(1, 8));
				h = 9'($urandom_range(1, 8));
				src_idle = 1'b0;
			end
			if (p >= RAND_PHASES - CALM_PHASES) begin
				src_idle = 1'b0;
				sink_idle = 1'b0;
			end
			color = ($urandom_range(0, 5) == 0) ? '0 : 32'($urandom);
			start_phase(w, h, color, src_idle, sink_idle);
			for (n = 0; n < CMDS_PER_PHASE; n++) begin
				r = $urandom_range(0, 99);
				if (r < 28) c.op = OP_ROW;
				else if (r < 55) c.op = OP_COL;
				else if (r < 74) c.op = OP_RECT;
				else if (r < 90) c.op = OP_READ;
				else if (r < 98) c.op = OP_SCALE;
				else c.op = 3'(OP_SCALE + $urandom_range(1, 3));
				c.x1 = rand_coord(surf_cols());
				c.y1 = rand_coord(surf_rows());
				c.x2 = rand_coord(surf_cols());
				c.y2 = rand_coord(surf_rows());
				// multipliers lean high so the frame does not fade to zero
				if ($urandom_range(0, 9) == 0) begin
					c.scale = '1;
				end else begin
					for (b = 0; b < 4; b++)
						c.scale[8*b +: 8] = ($urandom_range(0, 3) == 0) ?
							8'($urandom) : 8'($urandom_range(200, 255));
				end
				draw_cmds.push_back(c);
			end
			wait_drained();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d commands (%0d directed) over %0d surface settings, %0d result beats checked",
			cmds_sent, directed, RAND_PHASES + 3, beats_checked);
		$display("Receiver held off %0d cycles once; %0d mismatches", HOLD_CYCLES, fail_count);
		if (fail_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
